// ===== hdl/ipa_pkg.sv =====
// Shared types and constants of the interval partition assigner.
`timescale 1ns / 1ps
`default_nettype none

package ipa_pkg;

  localparam int ID_W            = 32;
  localparam int TS_W            = 32;
  localparam int LEVEL_W         = 5;
  localparam int PART_W          = 20;
  localparam int NUM_BITS_W      = 5;
  localparam int DOMAIN_BITS_W   = 6;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int NUM_BITS_RST    = 10;
  localparam int DOMAIN_BITS_RST = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TIME   = 2'd2;

  typedef enum logic [1:0] {
    CLS_ORIG_IN,
    CLS_ORIG_AFTER,
    CLS_REPL_IN,
    CLS_REPL_AFTER
  } cls_t;

  typedef struct packed {
    logic [ID_W-1:0]    record_tag;
    logic [LEVEL_W-1:0] level;
    logic [PART_W-1:0]  partition;
    cls_t               cell_class;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/ipa_fifo.sv =====
// Small register-based queue with first-word fall-through read.
`timescale 1ns / 1ps
`default_nettype none

module ipa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4   // power of two, at least 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ipa_front.sv =====
// Front end: drop reversed intervals, normalize both ends onto the bottom-level grid.
`timescale 1ns / 1ps
`default_nettype none

module ipa_front #(
  parameter int MAX_NUM_BITS = 20,
  parameter int TIME_WIDTH   = 32
) (
  input  wire logic                             in_push,
  input  wire logic [ipa_pkg::ID_W-1:0]         in_record_id,
  input  wire logic [ipa_pkg::TS_W-1:0]         in_start_time,
  input  wire logic [ipa_pkg::TS_W-1:0]         in_end_time,
  input  wire logic [$clog2(MAX_NUM_BITS+2)-1:0] nb,
  input  wire logic [$clog2(TIME_WIDTH+1)-1:0]   db,
  input  wire logic [ipa_pkg::TS_W-1:0]         base_time,
  output logic                                  q_push,
  output logic [ipa_pkg::ID_W+2*MAX_NUM_BITS-1:0] q_data
);

  import ipa_pkg::*;

  localparam int TW  = TIME_WIDTH;
  localparam int MNB = MAX_NUM_BITS;
  localparam int LW  = $clog2(MAX_NUM_BITS + 2);
  localparam int DBW = $clog2(TIME_WIDTH + 1);
  localparam int CW  = (LW > DBW) ? LW : DBW;

  function automatic logic [TW-1:0] norm(input logic [TW-1:0] t,
                                         input logic [TW-1:0] b,
                                         input logic [TW-1:0] top);
    logic [TW-1:0] d;
    d = t - b;
    if (t < b) begin
      return '0;
    end
    return (d > top) ? top : d;
  endfunction

  logic [TW-1:0] s_t, e_t, b_t, top, s_n, e_n;
  logic [CW-1:0] db_c, nb_c, sh;

  always_comb begin
    s_t  = TW'(in_start_time);
    e_t  = TW'(in_end_time);
    b_t  = TW'(base_time);
    db_c = CW'(db);
    nb_c = CW'(nb);
    sh   = (db_c > nb_c) ? db_c - nb_c : '0;
    if (32'(db) >= TW) begin
      top = '1;
    end else begin
      top = (TW'(1) << db) - TW'(1);
    end
    s_n    = norm(s_t, b_t, top) >> sh;
    e_n    = norm(e_t, b_t, top) >> sh;
    // Reversed intervals are consumed here and never reach the walker.
    q_push = in_push && !(s_t > e_t);
    q_data = {in_record_id, MNB'(s_n), MNB'(e_n)};
  end

endmodule

`default_nettype wire

// ===== hdl/ipa_walker.sv =====
// Back end: walk the index levels and emit the cell assignments of one record at a time.
`timescale 1ns / 1ps
`default_nettype none

module ipa_walker #(
  parameter int MAX_NUM_BITS = 20
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [$clog2(MAX_NUM_BITS+2)-1:0]     nb,
  input  wire logic                                 mid_empty,
  input  wire logic [ipa_pkg::ID_W+2*MAX_NUM_BITS-1:0] mid_data,
  output logic                                      mid_pop,
  input  wire logic                                 op_full,
  output logic                                      op_push,
  output ipa_pkg::res_t                             op_data
);

  import ipa_pkg::*;

  localparam int MNB = MAX_NUM_BITS;
  localparam int AW  = MAX_NUM_BITS + 2;
  localparam int LW  = $clog2(MAX_NUM_BITS + 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEFT,
    ST_RIGHT
  } state_t;

  state_t               state_r, state_nxt;
  logic signed [AW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [LW-1:0]        level_r, level_nxt;
  logic                 first_r, first_nxt;
  logic                 lastin_r, lastin_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  res_t                 pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;

  logic                 r_take, l_eq, r_orig, r_lastin;
  logic                 done, stall, left_now;
  logic signed [AW-1:0] a_aft, b_dec, b_new;
  logic                 first_aft, lastin_aft;
  cls_t                 l_cls, r_cls;
  res_t                 res_new;

  always_comb begin
    // Left end: odd index takes its cell, never tested in the right phase.
    left_now   = (state_r == ST_LEFT) && a_r[0];
    l_eq       = (a_r == b_r) && !lastin_r;
    if (l_eq) begin
      l_cls = first_r ? CLS_REPL_IN : CLS_ORIG_IN;
    end else begin
      l_cls = first_r ? CLS_REPL_AFTER : CLS_ORIG_AFTER;
    end
    a_aft      = left_now ? a_r + AW'(1) : a_r;
    first_aft  = first_r | left_now;
    lastin_aft = lastin_r | (left_now && l_eq && first_r);

    // Right end: even index takes its cell, seen after the left step.
    r_take   = !b_r[0];
    b_dec    = b_r - AW'(1);
    r_orig   = !first_aft && (b_dec < a_aft);
    if (r_orig) begin
      r_cls    = lastin_aft ? CLS_ORIG_AFTER : CLS_ORIG_IN;
      r_lastin = lastin_aft;
    end else begin
      r_cls    = lastin_aft ? CLS_REPL_AFTER : CLS_REPL_IN;
      r_lastin = 1'b1;
    end

    res_new.record_tag = id_r;
    res_new.level      = LEVEL_W'(level_r);
    res_new.partition  = left_now ? PART_W'(a_r[MNB-1:0]) : PART_W'(b_r[MNB-1:0]);
    res_new.cell_class = left_now ? l_cls : r_cls;
    res_new.last       = 1'b0;

    done  = (level_r > nb) || (a_r > b_r);
    stall = pend_v_r && op_full;

    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    level_nxt  = level_r;
    first_nxt  = first_r;
    lastin_nxt = lastin_r;
    id_nxt     = id_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    mid_pop    = 1'b0;
    op_push    = 1'b0;
    op_data    = pend_r;
    b_new      = b_r;

    case (state_r)
      ST_IDLE: begin
        if (!mid_empty) begin
          mid_pop    = 1'b1;
          id_nxt     = mid_data[ID_W+2*MNB-1 -: ID_W];
          a_nxt      = AW'(mid_data[2*MNB-1:MNB]);
          b_nxt      = AW'(mid_data[MNB-1:0]);
          level_nxt  = '0;
          first_nxt  = 1'b0;
          lastin_nxt = 1'b0;
          state_nxt  = ST_LEFT;
        end
      end
      ST_LEFT, ST_RIGHT: begin
        if (!stall) begin
          if (done) begin
            // Flush the held result as the record's final beat.
            op_push      = pend_v_r;
            op_data.last = 1'b1;
            pend_v_nxt   = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            if (left_now || r_take || state_r == ST_RIGHT) begin
              op_push    = pend_v_r;
              pend_nxt   = res_new;
              pend_v_nxt = 1'b1;
            end
            if (left_now && r_take) begin
              a_nxt      = a_aft;
              first_nxt  = first_aft;
              lastin_nxt = lastin_aft;
              state_nxt  = ST_RIGHT;
            end else begin
              if (r_take) begin
                b_new      = b_dec;
                lastin_nxt = r_lastin;
              end else begin
                lastin_nxt = lastin_aft;
              end
              a_nxt     = a_aft >>> 1;
              b_nxt     = b_new >>> 1;
              level_nxt = level_r + LW'(1);
              first_nxt = first_aft;
              state_nxt = ST_LEFT;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    level_r  <= level_nxt;
    first_r  <= first_nxt;
    lastin_r <= lastin_nxt;
    id_r     <= id_nxt;
    pend_r   <= pend_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/interval_partition_assigner.sv =====
// Top level of the interval partition assigner: config registers, front, queues, walker.
// Results: the walker holds a record's results one deep so that the last one can be marked,
//   and it takes a new record only once the current walk has ended.
// Walk steps: load the record, one step per level up to nb (the saturated num_bits), a second
//   step for a two-cell level, then a flush that marks the last result.
// Reset: synchronous active low; restores num_bits 10, domain_bits 32, base_time 0, empties queues.
`timescale 1ns / 1ps
`default_nettype none

module interval_partition_assigner #(
  parameter int MAX_NUM_BITS = 20,
  parameter int TIME_WIDTH   = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [ipa_pkg::ID_W-1:0]        in_record_id,
  input  wire logic [ipa_pkg::TS_W-1:0]        in_start_time,
  input  wire logic [ipa_pkg::TS_W-1:0]        in_end_time,
  // result channel
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [ipa_pkg::ID_W-1:0]             out_record_tag,
  output logic [ipa_pkg::LEVEL_W-1:0]          out_level,
  output logic [ipa_pkg::PART_W-1:0]           out_partition,
  output logic [1:0]                           out_cell_class,
  output logic                                 out_last,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [ipa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ipa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ipa_pkg::*;

  localparam int LW  = $clog2(MAX_NUM_BITS + 2);
  localparam int DBW = $clog2(TIME_WIDTH + 1);
  localparam int MW  = ID_W + 2 * MAX_NUM_BITS;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Configuration registers, written only while the block is idle: a user rule, unchecked here.
  logic [NUM_BITS_W-1:0]    num_bits_r, num_bits_nxt;
  logic [DOMAIN_BITS_W-1:0] domain_bits_r, domain_bits_nxt;
  logic [TS_W-1:0]          base_time_r, base_time_nxt;

  always_comb begin
    num_bits_nxt    = num_bits_r;
    domain_bits_nxt = domain_bits_r;
    base_time_nxt   = base_time_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_NUM_BITS:    num_bits_nxt    = cfg_data[NUM_BITS_W-1:0];
        REG_DOMAIN_BITS: domain_bits_nxt = cfg_data[DOMAIN_BITS_W-1:0];
        REG_BASE_TIME:   base_time_nxt   = cfg_data[TS_W-1:0];
        default: begin
          // Unmapped index: drop the beat.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bits_r    <= NUM_BITS_W'(NUM_BITS_RST);
      domain_bits_r <= DOMAIN_BITS_W'(DOMAIN_BITS_RST);
      base_time_r   <= '0;
    end else begin
      num_bits_r    <= num_bits_nxt;
      domain_bits_r <= domain_bits_nxt;
      base_time_r   <= base_time_nxt;
    end
  end

  // Saturate the level count and the domain width to what the datapath holds.
  logic [LW-1:0]  nb;
  logic [DBW-1:0] db;

  assign nb = (32'(num_bits_r) > MAX_NUM_BITS) ? LW'(MAX_NUM_BITS) : LW'(num_bits_r);
  assign db = (32'(domain_bits_r) > TIME_WIDTH) ? DBW'(TIME_WIDTH) : DBW'(domain_bits_r);

  // Front end feeds the short decoupling queue.
  logic          q_push, mid_full, mid_empty, mid_pop;
  logic [MW-1:0] q_data, mid_data;

  ipa_front #(
    .MAX_NUM_BITS (MAX_NUM_BITS),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_front (
    .in_push       (in_push && !mid_full),
    .in_record_id  (in_record_id),
    .in_start_time (in_start_time),
    .in_end_time   (in_end_time),
    .nb            (nb),
    .db            (db),
    .base_time     (base_time_r),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  assign in_full = mid_full;

  ipa_fifo #(
    .WIDTH (MW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_data),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_data),
    .empty (mid_empty)
  );

  // Walker produces result beats into the output queue, holding while the queue is full.
  logic op_full, op_push;
  res_t op_data, out_res;

  ipa_walker #(
    .MAX_NUM_BITS (MAX_NUM_BITS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .nb        (nb),
    .mid_empty (mid_empty),
    .mid_data  (mid_data),
    .mid_pop   (mid_pop),
    .op_full   (op_full),
    .op_push   (op_push),
    .op_data   (op_data)
  );

  ipa_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .wdata (op_data),
    .full  (op_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_record_tag = out_res.record_tag;
  assign out_level      = out_res.level;
  assign out_partition  = out_res.partition;
  assign out_cell_class = out_res.cell_class;
  assign out_last       = out_res.last;

endmodule

`default_nettype wire

// ===== hdl/ipa_checker.sv =====
// Port-level checks of the interval partition assigner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ipa_checker #(
  parameter int MAX_NUM_BITS = 20
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [31:0] out_record_tag,
  input wire logic [4:0]  out_level,
  input wire logic [19:0] out_partition,
  input wire logic [1:0]  out_cell_class,
  input wire logic        out_last
);

  // Reset leaves the result queue empty and the input queue not full.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting beat holds until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_record_tag) &&
      $stable(out_level) && $stable(out_partition) && $stable(out_cell_class) &&
      $stable(out_last))
    else $error("result beat changed before pop");

  // No level beyond the root.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> 32'(out_level) <= MAX_NUM_BITS)
    else $error("result level above root");

  // A cell number fits the width of its level.
  a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (64'(out_partition) >> (MAX_NUM_BITS - 32'(out_level))) == 64'd0)
    else $error("partition beyond level width");

endmodule

bind interval_partition_assigner ipa_checker #(.MAX_NUM_BITS(MAX_NUM_BITS)) u_ipa_checker (.*);

`default_nettype wire

// ===== tb/interval_partition_assigner_test.sv =====
// Self-checking testbench for the interval partition assigner: directed and random records.
`timescale 1ns / 1ps

module interval_partition_assigner_test;
  import ipa_pkg::*;

  localparam int MAX_NB        = 20;
  // Quiet time before a register write or the final verdict; covers a full walk at the
  // largest index height plus the result holding stage.
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [ID_W-1:0]       in_record_id = '0;
  logic [TS_W-1:0]       in_start_time = '0;
  logic [TS_W-1:0]       in_end_time = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [ID_W-1:0]       out_record_tag;
  logic [LEVEL_W-1:0]    out_level;
  logic [PART_W-1:0]     out_partition;
  logic [1:0]            out_cell_class;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's configuration, updated only while the block is idle.
  logic [NUM_BITS_W-1:0]    cfg_num_bits = NUM_BITS_W'(NUM_BITS_RST);
  logic [DOMAIN_BITS_W-1:0] cfg_domain_bits = DOMAIN_BITS_W'(DOMAIN_BITS_RST);
  logic [TS_W-1:0]          cfg_base_time = '0;

  // Cell assignments predicted for accepted records, oldest first.
  res_t cells_due[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  interval_partition_assigner #(
    .MAX_NUM_BITS(MAX_NB),
    .TIME_WIDTH  (TS_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_record_id  (in_record_id),
    .in_start_time (in_start_time),
    .in_end_time   (in_end_time),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_record_tag(out_record_tag),
    .out_level     (out_level),
    .out_partition (out_partition),
    .out_cell_class(out_cell_class),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Map a raw timestamp into the normalized domain: drop the base, clamp to [0, top].
  function automatic longint unsigned to_domain(input logic [TS_W-1:0] t,
                                                input longint unsigned top);
    longint unsigned offset;
    if (t < cfg_base_time) return 0;
    offset = t - cfg_base_time;
    return (offset > top) ? top : offset;
  endfunction

  function automatic void add_cell(input logic [ID_W-1:0] id, input int unsigned lvl,
                                   input longint part, input cls_t cls);
    res_t entry;
    entry.record_tag = id;
    entry.level      = lvl[LEVEL_W-1:0];
    entry.partition  = part[PART_W-1:0];
    entry.cell_class = cls;
    entry.last       = 1'b0;
    cells_due.insert(cells_due.size(), entry);
  endfunction

  // Walk the index from the leaves up and queue every cell the interval lands in.
  function automatic void predict_cells(input logic [ID_W-1:0] id,
                                        input logic [TS_W-1:0] t_start,
                                        input logic [TS_W-1:0] t_end);
    int unsigned     nb;
    int unsigned     db;
    int unsigned     shift;
    int unsigned     lvl;
    longint unsigned top;
    longint          lo;
    longint          hi;
    longint          hi_cell;
    bit              took_first;
    bit              took_in;
    int              first_pos;
    // A reversed interval is dropped without a single assignment.
    if (t_start > t_end) return;
    nb    = (cfg_num_bits > MAX_NB) ? MAX_NB : cfg_num_bits;
    db    = (cfg_domain_bits > TS_W) ? TS_W : cfg_domain_bits;
    top   = (db == 0) ? 64'd0 : ((64'd1 << db) - 64'd1);
    shift = (db > nb) ? db - nb : 0;
    lo    = longint'(to_domain(t_start, top) >> shift);
    hi    = longint'(to_domain(t_end, top) >> shift);
    lvl   = 0;
    took_first = 1'b0;
    took_in    = 1'b0;
    first_pos  = cells_due.size();
    while (lvl <= nb && lo <= hi) begin
      // Left end sits on a right child: take its cell, step past it.
      if (lo[0]) begin
        if (took_first) begin
          if (lo == hi && !took_in) begin
            add_cell(id, lvl, lo, CLS_REPL_IN);
            took_in = 1'b1;
          end else begin
            add_cell(id, lvl, lo, CLS_REPL_AFTER);
          end
        end else begin
          // An original never closes the search for the "in" cell.
          if (lo == hi && !took_in) begin
            add_cell(id, lvl, lo, CLS_ORIG_IN);
          end else begin
            add_cell(id, lvl, lo, CLS_ORIG_AFTER);
          end
          took_first = 1'b1;
        end
        lo = lo + 1;
      end
      // Right end sits on a left child: take its cell, step before it.
      if (!hi[0]) begin
        hi_cell = hi;
        hi = hi - 1;
        if (!took_first && hi < lo) begin
          if (took_in) begin
            add_cell(id, lvl, hi_cell, CLS_ORIG_AFTER);
          end else begin
            add_cell(id, lvl, hi_cell, CLS_ORIG_IN);
          end
        end else if (!took_in) begin
          add_cell(id, lvl, hi_cell, CLS_REPL_IN);
          took_in = 1'b1;
        end else begin
          add_cell(id, lvl, hi_cell, CLS_REPL_AFTER);
        end
      end
      lo  = lo >>> 1;
      hi  = (hi < 0) ? -64'sd1 : (hi >>> 1);
      lvl = lvl + 1;
    end
    if (cells_due.size() > first_pos) cells_due[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side: random pop stalls and the field-by-field check
  // ---------------------------------------------------------------------------------------

  // Drop pop for bursts of random length while receive idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_pop    <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_pop    <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Compare each popped beat against the oldest predicted cell.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (cells_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat, expected none, actual tag %h level %0d part %h",
                 $time, out_record_tag, out_level, out_partition);
      end else begin
        want = cells_due.pop_front();
        check_field("record_tag", want.record_tag, out_record_tag);
        check_field("level", 32'(want.level), 32'(out_level));
        check_field("partition", 32'(want.partition), 32'(out_partition));
        check_field("cell_class", 32'(want.cell_class), 32'(out_cell_class));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------------------

  // Offer one record, hold it until the block takes it, then maybe idle a burst.
  // Push is left high otherwise, so back-to-back records stream without a bubble.
  task automatic send_record(input logic [ID_W-1:0] id, input logic [TS_W-1:0] t_start,
                             input logic [TS_W-1:0] t_end);
    in_push       <= 1'b1;
    in_record_id  <= id;
    in_start_time <= t_start;
    in_end_time   <= t_end;
    do @(posedge clk); while (in_full);
    predict_cells(id, t_start, t_end);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop push, wait for every predicted cell, then hold off a while longer.
  task automatic settle(input int extra);
    in_push <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write all three registers back to back once the block has gone quiet.
  task automatic set_config(input logic [NUM_BITS_W-1:0] nb,
                            input logic [DOMAIN_BITS_W-1:0] db,
                            input logic [TS_W-1:0] base);
    settle(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_BITS;
    cfg_data  <= CFG_DATA_W'(nb);
    @(posedge clk);
    cfg_index <= REG_DOMAIN_BITS;
    cfg_data  <= CFG_DATA_W'(db);
    @(posedge clk);
    cfg_index <= REG_BASE_TIME;
    cfg_data  <= base;
    @(posedge clk);
    cfg_we          <= 1'b0;
    cfg_num_bits    = nb;
    cfg_domain_bits = db;
    cfg_base_time   = base;
  endtask

  // Mostly well-formed intervals placed inside the current domain, with spans of every
  // scale; the rest is raw noise, reversed intervals and starts below the base.
  task automatic send_random_record(output bit live);
    logic [TS_W-1:0] t_start;
    logic [TS_W-1:0] t_end;
    logic [TS_W-1:0] span;
    longint unsigned reach;
    int unsigned     db;
    int              kind;
    kind    = $urandom_range(0, 9);
    db      = (cfg_domain_bits > TS_W) ? TS_W : cfg_domain_bits;
    reach   = (64'd1 << db) - 64'd1;
    span    = TS_W'($urandom & ((64'd1 << $urandom_range(0, 32)) - 64'd1));
    t_start = cfg_base_time + ($urandom & reach[TS_W-1:0]);
    t_end   = t_start + span;
    if (t_end < t_start) t_end = '1;
    case (kind)
      0: begin
        t_start = $urandom;
        t_end   = $urandom;
      end
      1: t_end = t_start - $urandom_range(1, 1000);
      2: t_end = t_start;
      3: t_start = cfg_base_time - $urandom_range(0, 5000);
      default: ;
    endcase
    live = (t_start <= t_end);
    send_record($urandom, t_start, t_end);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset configuration: extreme ids and times, a point interval, a reversed one.
  task automatic test_reset_config();
    send_record(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_record(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_record(32'hA5A5_5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(32'h0000_0001, 32'h0000_0005, 32'h0000_0004);
    send_record(32'h5A5A_A5A5, 32'h0040_0000, 32'h00BF_FFFF);
    send_record(32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
  endtask

  // Base subtraction clamps at zero, the domain top clamps large times.
  task automatic test_clamping();
    set_config(8, 16, 32'h0001_0000);
    send_record(32'h0000_0010, 32'h0000_0100, 32'h0000_0200);
    send_record(32'h0000_0011, 32'h0000_0000, 32'h0001_8000);
    send_record(32'h0000_0012, 32'h0001_8000, 32'hFFFF_FFFF);
    send_record(32'h0000_0013, 32'h3000_0000, 32'h4000_0000);
    set_config(4, 8, 32'hFFFF_FFFF);
    send_record(32'h0000_0014, 32'h0000_0000, 32'hFFFF_FFFE);
    send_record(32'h0000_0015, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Oversized registers saturate; a zero height is root only; a zero domain maps
  // everything to zero; a domain narrower than the height gives no shift.
  task automatic test_saturation();
    set_config(31, 63, 32'h0000_0000);
    send_record(32'h0000_0020, 32'h0000_0000, 32'hFFFF_FFFF);
    send_record(32'h0000_0021, 32'h0000_1000, 32'h8000_0000);
    set_config(0, 32, 32'h0000_0000);
    send_record(32'h0000_0022, 32'h0000_0003, 32'h0009_0000);
    send_record(32'h0000_0023, 32'h0000_000A, 32'h0000_0009);
    set_config(6, 0, 32'h0000_0000);
    send_record(32'h0000_0024, 32'h0000_0001, 32'hFFFF_FFFF);
    set_config(12, 4, 32'h0000_0000);
    send_record(32'h0000_0025, 32'h0000_0003, 32'h0000_000B);
    send_record(32'h0000_0026, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // Let the result queue run dry mid-stream, then resume.
  task automatic test_pause_for_drain();
    bit live;
    set_config(5, 12, 32'h0000_0100);
    repeat (10) send_random_record(live);
    settle(1);
    repeat (10) send_random_record(live);
  endtask

  // Random configurations, mostly small heights, with random idling on each side.
  task automatic test_random_phases();
    logic [NUM_BITS_W-1:0]    nb;
    logic [DOMAIN_BITS_W-1:0] db;
    logic [TS_W-1:0]          base;
    int                       live_count;
    bit                       live;
    for (int phase = 0; phase < 6; phase++) begin
      nb   = ($urandom_range(0, 3) != 0) ? NUM_BITS_W'($urandom_range(0, 8))
                                         : NUM_BITS_W'($urandom_range(9, 31));
      db   = ($urandom_range(0, 3) != 0) ? DOMAIN_BITS_W'($urandom_range(nb, 32))
                                         : DOMAIN_BITS_W'($urandom_range(0, 63));
      base = $urandom_range(0, 1) ? $urandom : 32'h0;
      set_config(nb, db, base);
      send_idle  = ($urandom_range(0, 3) != 0);
      recv_idle  = ($urandom_range(0, 3) != 0);
      live_count = 0;
      while (live_count < 20) begin
        send_random_record(live);
        if (live) live_count++;
      end
    end
  endtask

  // Tallest index at full rate on both sides, no idling.
  task automatic test_full_rate();
    int live_count;
    bit live;
    set_config(NUM_BITS_W'(MAX_NB), DOMAIN_BITS_W'(TS_W), $urandom);
    send_idle  = 1'b0;
    recv_idle  = 1'b0;
    live_count = 0;
    while (live_count < 25) begin
      send_random_record(live);
      if (live) live_count++;
    end
  endtask

  initial begin
    // Hold reset from the start, then release it for good.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_clamping();
    test_saturation();
    test_pause_for_drain();
    test_random_phases();
    test_full_rate();
    settle(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
